[rtl/core/fcd_pkg.sv]
package fcd_pkg;

    // Defaults and sizing
    localparam int NOTE_COUNT_DEF = 7;
    localparam int QUEUE_DEPTH    = 2;

    // Frame bytes and command codes
    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] CMD_CALC   = 8'h01;
    localparam logic [7:0] CMD_ADC    = 8'h02;
    localparam logic [7:0] CMD_BUZ    = 8'h03;
    localparam logic [7:0] ADC_GO     = 8'h08;
    localparam logic [7:0] BUZ_ON     = 8'h10;
    localparam logic [7:0] BUZ_OFF    = 8'h20;
    localparam logic [7:0] BUZ_UP     = 8'h40;

    // Calc payload positions, counted as bytes still to come
    localparam logic [7:0] OPER_SLOT  = 8'd3;
    localparam logic [7:0] OPND_SLOT  = 8'd2;
    localparam logic [7:0] OPER_FIRST = 8'd1;
    localparam logic [7:0] OPER_LAST  = 8'd4;

    // Tone table: timer top = 1 MHz / (f + 1)
    localparam int TONE_CLOCK = 1000000;
    localparam int TONE_COUNT = 7;
    localparam logic [15:0] TONE_PERIOD [TONE_COUNT] = '{
        16'(TONE_CLOCK / (2093 + 1)),
        16'(TONE_CLOCK / (2349 + 1)),
        16'(TONE_CLOCK / (2637 + 1)),
        16'(TONE_CLOCK / (2794 + 1)),
        16'(TONE_CLOCK / (3136 + 1)),
        16'(TONE_CLOCK / (3520 + 1)),
        16'(TONE_CLOCK / (3951 + 1))
    };

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEN,
        PH_CMD,
        PH_BODY
    } phase_t;

    typedef enum logic [2:0] {
        JOB_NONE,
        JOB_UNKNOWN,
        JOB_CALC,
        JOB_ADC,
        JOB_BUZ
    } job_kind_t;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV
    } calc_op_t;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_CALC,
        ACT_ADC_START,
        ACT_ADC_STOP,
        ACT_BUZ_ON,
        ACT_BUZ_OFF,
        ACT_NOTE
    } action_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_WB
    } back_state_t;

    // One classified item, front to back
    typedef struct packed {
        job_kind_t   kind;
        logic        op_valid;
        calc_op_t    op;
        logic [7:0]  opnd_a;
        logic [7:0]  opnd_b;
        logic [7:0]  payload;
    } job_t;

    typedef struct packed {
        logic        frame_done;
        action_t     action;
        logic [15:0] calc_result;
        logic        divide_by_zero;
        logic        timer_start;
        logic        timer_stop;
        logic        adc_burst_on;
        logic        buzzer_on;
        logic [2:0]  note_index;
        logic [15:0] tone_period;
        logic        play_pulse;
    } result_t;

    // Note index reduced modulo the seven-entry table
    function automatic logic [15:0] tone_period_of(input logic [3:0] note);
        logic [3:0] idx;
        if (note >= 4'(2 * TONE_COUNT))
            idx = note - 4'(2 * TONE_COUNT);
        else if (note >= 4'(TONE_COUNT))
            idx = note - 4'(TONE_COUNT);
        else
            idx = note;
        return TONE_PERIOD[idx[2:0]];
    endfunction

endpackage

[rtl/core/fcd_front.sv]
module fcd_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    rx_byte,
    output fcd_pkg::job_t job
);
    import fcd_pkg::*;

    phase_t     phase_reg,    phase_next;
    logic [7:0] left_reg,     left_next;
    logic [7:0] cmd_reg,      cmd_next;
    logic       op_valid_reg, op_valid_next;
    calc_op_t   op_reg,       op_next;
    logic [7:0] a_reg,        a_next;
    logic [7:0] b_reg,        b_next;
    logic [7:0] adc_pl_reg,   adc_pl_next;
    logic [7:0] buz_pl_reg,   buz_pl_next;

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        left_next     = left_reg;
        cmd_next      = cmd_reg;
        op_valid_next = op_valid_reg;
        op_next       = op_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        adc_pl_next   = adc_pl_reg;
        buz_pl_next   = buz_pl_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == START_BYTE)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                left_next  = rx_byte - 8'd1;
                phase_next = PH_CMD;
            end
            PH_CMD:
            begin
                cmd_next   = rx_byte;
                left_next  = left_reg - 8'd1;
                phase_next = PH_BODY;
            end
            PH_BODY:
            begin
                if (left_reg != 8'd0)
                begin
                    left_next = left_reg - 8'd1;
                    priority if (cmd_reg == CMD_CALC)
                    begin
                        priority if (left_reg == OPER_SLOT)
                        begin
                            if (rx_byte >= OPER_FIRST && rx_byte <= OPER_LAST)
                            begin
                                op_valid_next = 1'b1;
                                op_next       = calc_op_t'(2'(rx_byte - OPER_FIRST));
                            end
                        end
                        else if (left_reg == OPND_SLOT)
                            a_next = rx_byte;
                        else
                            b_next = rx_byte;
                    end
                    else if (cmd_reg == CMD_ADC)
                        adc_pl_next = rx_byte;
                    else if (cmd_reg == CMD_BUZ)
                        buz_pl_next = rx_byte;
                    else
                    begin
                        // unknown command: payload counted, not kept
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    left_next  = 8'd0;
                    if (cmd_reg == CMD_CALC)
                    begin
                        op_valid_next = 1'b0;
                        a_next        = 8'd0;
                        b_next        = 8'd0;
                    end
                    if (cmd_reg == CMD_ADC)
                        adc_pl_next = 8'd0;
                    if (cmd_reg == CMD_BUZ)
                        buz_pl_next = 8'd0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Classified item for this byte
    always_comb
    begin
        job.kind     = JOB_NONE;
        job.op_valid = op_valid_reg;
        job.op       = op_reg;
        job.opnd_a   = a_reg;
        job.opnd_b   = b_reg;
        job.payload  = (cmd_reg == CMD_ADC) ? adc_pl_reg : buz_pl_reg;
        if (phase_reg == PH_BODY && left_reg == 8'd0)
        begin
            priority if (cmd_reg == CMD_CALC)
                job.kind = JOB_CALC;
            else if (cmd_reg == CMD_ADC)
                job.kind = JOB_ADC;
            else if (cmd_reg == CMD_BUZ)
                job.kind = JOB_BUZ;
            else
                job.kind = JOB_UNKNOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            left_reg     <= 8'd0;
            cmd_reg      <= 8'd0;
            op_valid_reg <= 1'b0;
            op_reg       <= OP_ADD;
            a_reg        <= 8'd0;
            b_reg        <= 8'd0;
            adc_pl_reg   <= 8'd0;
            buz_pl_reg   <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            cmd_reg      <= cmd_next;
            op_valid_reg <= op_valid_next;
            op_reg       <= op_next;
            a_reg        <= a_next;
            b_reg        <= b_next;
            adc_pl_reg   <= adc_pl_next;
            buz_pl_reg   <= buz_pl_next;
        end
    end

endmodule

[rtl/core/fcd_queue.sv]
module fcd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  fcd_pkg::job_t push_job,
    input  logic          pop,
    output logic          full,
    output logic          not_empty,
    output fcd_pkg::job_t head
);
    import fcd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

endmodule

[rtl/core/fcd_back.sv]
module fcd_back #(
    parameter int NOTE_COUNT = fcd_pkg::NOTE_COUNT_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  fcd_pkg::job_t    head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output fcd_pkg::result_t res
);
    import fcd_pkg::*;

    localparam int NOTE_W = (NOTE_COUNT > 2) ? $clog2(NOTE_COUNT) : 1;

    back_state_t     state_reg, state_next;
    logic [15:0]     last_reg;
    logic            adc_en_reg;
    logic            buz_en_reg;
    logic [NOTE_W-1:0] note_reg;
    logic            out_valid_reg;
    result_t         res_reg;

    // Divider
    logic [7:0] quo_reg, quo_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] dvs_reg;
    logic [2:0] cnt_reg;
    logic [8:0] shifted;

    logic slot_free, head_is_div;
    logic div_load, ex_load, wb_load;

    // Immediate execution
    logic [15:0]       ex_last;
    logic              ex_adc, ex_buz;
    logic [NOTE_W-1:0] ex_note;
    result_t           ex_res, wb_res;

    assign slot_free   = !out_valid_reg || !out_stall;
    assign head_is_div = (head.kind == JOB_CALC) && head.op_valid
                         && (head.op == OP_DIV) && (head.opnd_b != 8'd0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (q_valid && head_is_div) state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == 3'd7)         state_next = BK_WB;
            BK_WB:   if (slot_free)               state_next = BK_IDLE;
            default:                              state_next = BK_IDLE;
        endcase
    end

    // Controls
    always_comb
    begin
        pop      = 1'b0;
        div_load = 1'b0;
        ex_load  = 1'b0;
        wb_load  = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                div_load = q_valid && head_is_div;
                ex_load  = q_valid && !head_is_div && slot_free;
                pop      = div_load || ex_load;
            end
            BK_WB:   wb_load = slot_free;
            BK_DIV:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Restoring step, one quotient bit a cycle
    always_comb
    begin
        shifted = {rem_reg, quo_reg[7]};
        if (shifted >= {1'b0, dvs_reg})
        begin
            rem_next = 8'(shifted - {1'b0, dvs_reg});
            quo_next = {quo_reg[6:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[7:0];
            quo_next = {quo_reg[6:0], 1'b0};
        end
    end

    always_comb
    begin
        ex_last = last_reg;
        ex_adc  = adc_en_reg;
        ex_buz  = buz_en_reg;
        ex_note = note_reg;
        ex_res  = '0;
        unique case (head.kind)
            JOB_NONE:
            begin
            end
            JOB_UNKNOWN: ex_res.frame_done = 1'b1;
            JOB_CALC:
            begin
                ex_res.frame_done = 1'b1;
                ex_res.action     = ACT_CALC;
                if (!head.op_valid)
                begin
                    ex_last             = 16'd0;
                    ex_res.timer_stop   = 1'b1;
                end
                else
                begin
                    ex_res.timer_start = 1'b1;
                    unique case (head.op)
                        OP_ADD: ex_last = {8'd0, head.opnd_a} + {8'd0, head.opnd_b};
                        OP_SUB: ex_last = {8'd0, head.opnd_a} - {8'd0, head.opnd_b};
                        OP_MUL: ex_last = {8'd0, head.opnd_a} * {8'd0, head.opnd_b};
                        OP_DIV:
                        begin
                            // only a zero divisor is executed here
                            ex_last               = 16'd0;
                            ex_res.divide_by_zero = 1'b1;
                        end
                        default: ex_last = 16'd0;
                    endcase
                end
            end
            JOB_ADC:
            begin
                ex_res.frame_done = 1'b1;
                if (head.payload == ADC_GO)
                begin
                    ex_adc             = 1'b1;
                    ex_res.timer_start = 1'b1;
                    ex_res.action      = ACT_ADC_START;
                end
                else
                begin
                    ex_adc        = 1'b0;
                    ex_res.action = ACT_ADC_STOP;
                end
            end
            JOB_BUZ:
            begin
                ex_res.frame_done = 1'b1;
                priority if (head.payload == BUZ_ON)
                begin
                    ex_buz        = 1'b1;
                    ex_res.action = ACT_BUZ_ON;
                end
                else if (head.payload == BUZ_OFF)
                begin
                    ex_buz        = 1'b0;
                    ex_res.action = ACT_BUZ_OFF;
                end
                else if (head.payload == BUZ_UP)
                begin
                    ex_note = (note_reg == NOTE_W'(NOTE_COUNT - 1)) ? '0
                                                                   : note_reg + NOTE_W'(1);
                    ex_res.action = ACT_NOTE;
                end
                else
                begin
                    if (note_reg != '0)
                        ex_note = note_reg - NOTE_W'(1);
                    ex_res.action     = ACT_NOTE;
                    ex_res.play_pulse = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        ex_res.calc_result  = ex_last;
        ex_res.adc_burst_on = ex_adc;
        ex_res.buzzer_on    = ex_buz;
        ex_res.note_index   = 3'(ex_note);
        ex_res.tone_period  = tone_period_of(4'(ex_note));
    end

    always_comb
    begin
        wb_res              = '0;
        wb_res.frame_done   = 1'b1;
        wb_res.action       = ACT_CALC;
        wb_res.timer_start  = 1'b1;
        wb_res.calc_result  = {8'd0, quo_reg};
        wb_res.adc_burst_on = adc_en_reg;
        wb_res.buzzer_on    = buz_en_reg;
        wb_res.note_index   = 3'(note_reg);
        wb_res.tone_period  = tone_period_of(4'(note_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 3'd0;
            last_reg      <= 16'd0;
            adc_en_reg    <= 1'b0;
            buz_en_reg    <= 1'b0;
            note_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (div_load)
                cnt_reg <= 3'd0;
            else if (state_reg == BK_DIV)
                cnt_reg <= cnt_reg + 3'd1;
            if (ex_load)
            begin
                last_reg   <= ex_last;
                adc_en_reg <= ex_adc;
                buz_en_reg <= ex_buz;
                note_reg   <= ex_note;
            end
            else if (wb_load)
                last_reg <= {8'd0, quo_reg};
            if (ex_load || wb_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_load)
        begin
            quo_reg <= head.opnd_a;
            rem_reg <= 8'd0;
            dvs_reg <= head.opnd_b;
        end
        else if (state_reg == BK_DIV)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
        if (ex_load)
            res_reg <= ex_res;
        else if (wb_load)
            res_reg <= wb_res;
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

endmodule

[rtl/core/framed_command_decoder_unit.sv]
// Framed command decoder. Takes received serial bytes, one item per byte, and
// gives exactly one result item for every byte: frames are 0x02, length,
// command, payload and a final byte, and the final byte runs the command
// (calc, ADC burst start/stop, buzzer on/off/note step). Bytes enter on
// in_valid/in_stall; results leave on out_valid/out_stall and stay put while
// stalled. A front parser classifies each byte and pushes it into a two-item
// queue; the back unit executes from that queue into a result register.
// Rate: the front takes one byte a cycle while the queue has room. The back
// executes an item directly, except a divide with non-zero divisor, which goes
// through an 8-step restoring divider (pop, eight quotient bits, write back)
// and takes no new item until done. The divider is what sets the worst case;
// sustained rate is one byte per cycle outside divides, while out_stall is low.
module framed_command_decoder_unit #(
    parameter int NOTE_COUNT = fcd_pkg::NOTE_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        frame_done,
    output logic [2:0]  action,
    output logic [15:0] calc_result,
    output logic        divide_by_zero,
    output logic        timer_start,
    output logic        timer_stop,
    output logic        adc_burst_on,
    output logic        buzzer_on,
    output logic [2:0]  note_index,
    output logic [15:0] tone_period,
    output logic        play_pulse
);
    import fcd_pkg::*;

    job_t    front_job;
    job_t    head_job;
    logic    q_full, q_valid, q_pop;
    logic    accept;
    result_t res;

    // Queue full holds off the sender
    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    fcd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .rx_byte (rx_byte),
        .job     (front_job)
    );

    fcd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_job  (front_job),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head      (head_job)
    );

    fcd_back #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .head      (head_job),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // Result register fields out to the ports
    assign frame_done     = res.frame_done;
    assign action         = res.action;
    assign calc_result    = res.calc_result;
    assign divide_by_zero = res.divide_by_zero;
    assign timer_start    = res.timer_start;
    assign timer_stop     = res.timer_stop;
    assign adc_burst_on   = res.adc_burst_on;
    assign buzzer_on      = res.buzzer_on;
    assign note_index     = res.note_index;
    assign tone_period    = res.tone_period;
    assign play_pulse     = res.play_pulse;

endmodule

[rtl/core/fcd_checker.sv]
module fcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        frame_done,
    input logic [2:0]  action,
    input logic [15:0] calc_result,
    input logic        divide_by_zero,
    input logic        timer_start,
    input logic        timer_stop,
    input logic [15:0] tone_period,
    input logic        play_pulse
);
    import fcd_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(calc_result)
            && $stable(action) && $stable(frame_done) && $stable(tone_period))
        else $error("stalled result changed");

    // pulses only on a completed frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !frame_done |-> action == ACT_NONE && !divide_by_zero
            && !timer_start && !timer_stop && !play_pulse)
        else $error("pulse without frame");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(timer_start && timer_stop))
        else $error("timer start and stop together");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_by_zero |-> calc_result == 16'd0
            && action == ACT_CALC && timer_start)
        else $error("bad divide by zero result");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && play_pulse |-> action == ACT_NOTE)
        else $error("play without note change");

endmodule

bind framed_command_decoder_unit fcd_checker u_fcd_checker (.*);
